FILE: rtl/hds_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Haversine distance package
// Shared constants, widths and the CORDIC arctangent table.
// ----------------------------------------------------------------------------
package hds_pkg;

  localparam int CORDIC_ITERS = 30;
  localparam int SQRT_ITERS   = 32;
  localparam int COS_W        = 34;
  localparam int ATAN_W       = 35;

  // Rotation CORDIC start value, Q30, compensates the CORDIC gain.
  localparam logic [29:0] CORDIC_GAIN = 30'd652032874;

  // Degrees to binary angle: q = floor((mag * 8192 + 22) / 45).
  // mag is split as 45 * t + u, so q = t * 8192 + 182 * u + bump(u).
  localparam logic [26:0] RECIP_45   = 27'd95443717;
  localparam logic [6:0]  FRAC_DIV   = 7'd45;
  localparam logic [7:0]  FRAC_STEP  = 8'd182;
  localparam logic [5:0]  FRAC_BUMP1 = 6'd12;
  localparam logic [5:0]  FRAC_BUMP2 = 6'd34;

  localparam logic [30:0] PI_Q29 = 31'd1686629713;

  localparam int RADIUS_W = 13;
  localparam logic [RADIUS_W-1:0] RADIUS_RESET = 13'd6373;

  localparam int DIST_FRAC_BITS = 8;
  localparam int DIST_SHIFT     = 27 - DIST_FRAC_BITS;
  localparam int DIST_W         = 23;

  localparam int ADDR_W = 2;
  localparam logic [ADDR_W-1:0] ADDR_RADIUS = 2'd0;

  // atan(2^-i) as a binary angle, 2^32 units per turn.
  function automatic logic [29:0] atan_entry(input int i);
    case (i)
      0:  return 30'h20000000;
      1:  return 30'h12E4051E;
      2:  return 30'h09FB385B;
      3:  return 30'h051111D4;
      4:  return 30'h028B0D43;
      5:  return 30'h0145D7E1;
      6:  return 30'h00A2F61E;
      7:  return 30'h00517C55;
      8:  return 30'h0028BE53;
      9:  return 30'h00145F2F;
      10: return 30'h000A2F98;
      11: return 30'h000517CC;
      12: return 30'h00028BE6;
      13: return 30'h000145F3;
      14: return 30'h0000A2FA;
      15: return 30'h0000517D;
      16: return 30'h000028BE;
      17: return 30'h0000145F;
      18: return 30'h00000A30;
      19: return 30'h00000518;
      20: return 30'h0000028C;
      21: return 30'h00000146;
      22: return 30'h000000A3;
      23: return 30'h00000051;
      24: return 30'h00000029;
      25: return 30'h00000014;
      26: return 30'h0000000A;
      27: return 30'h00000005;
      28: return 30'h00000003;
      29: return 30'h00000001;
      default: return 30'h0;
    endcase
  endfunction

endpackage

FILE: rtl/hds_cordic.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Pipelined CORDIC
// One micro-rotation per register stage, rotation or vectoring mode.
// ----------------------------------------------------------------------------
module hds_cordic
  import hds_pkg::*;
#(
  parameter int W      = COS_W,
  parameter bit VECTOR = 1'b0
) (
  input  logic                clk,
  input  logic                en,
  input  logic signed [W-1:0] x_in,
  input  logic signed [W-1:0] y_in,
  input  logic signed [W-1:0] z_in,
  output logic signed [W-1:0] x_out,
  output logic signed [W-1:0] y_out,
  output logic signed [W-1:0] z_out
);

  logic signed [W-1:0] x_q [CORDIC_ITERS];
  logic signed [W-1:0] y_q [CORDIC_ITERS];
  logic signed [W-1:0] z_q [CORDIC_ITERS];
  logic signed [W-1:0] x_p [CORDIC_ITERS];
  logic signed [W-1:0] y_p [CORDIC_ITERS];
  logic signed [W-1:0] z_p [CORDIC_ITERS];
  logic signed [W-1:0] x_next [CORDIC_ITERS];
  logic signed [W-1:0] y_next [CORDIC_ITERS];
  logic signed [W-1:0] z_next [CORDIC_ITERS];

  always_comb begin
    x_p[0] = x_in;
    y_p[0] = y_in;
    z_p[0] = z_in;
    for (int i = 1; i < CORDIC_ITERS; i++) begin
      x_p[i] = x_q[i-1];
      y_p[i] = y_q[i-1];
      z_p[i] = z_q[i-1];
    end
    for (int i = 0; i < CORDIC_ITERS; i++) begin
      // Rotation drives z toward zero, vectoring drives y toward zero.
      if (VECTOR ? y_p[i][W-1] : !z_p[i][W-1]) begin
        x_next[i] = x_p[i] - (y_p[i] >>> i);
        y_next[i] = y_p[i] + (x_p[i] >>> i);
        z_next[i] = z_p[i] - $signed({{(W-30){1'b0}}, atan_entry(i)});
      end else begin
        x_next[i] = x_p[i] + (y_p[i] >>> i);
        y_next[i] = y_p[i] - (x_p[i] >>> i);
        z_next[i] = z_p[i] + $signed({{(W-30){1'b0}}, atan_entry(i)});
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < CORDIC_ITERS; i++) begin
        x_q[i] <= x_next[i];
        y_q[i] <= y_next[i];
        z_q[i] <= z_next[i];
      end
    end
  end

  assign x_out = x_q[CORDIC_ITERS-1];
  assign y_out = y_q[CORDIC_ITERS-1];
  assign z_out = z_q[CORDIC_ITERS-1];

endmodule

FILE: rtl/hds_isqrt.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Pipelined integer square root
// Floor root of a 64-bit radicand, one result bit per register stage.
// ----------------------------------------------------------------------------
module hds_isqrt
  import hds_pkg::*;
(
  input  logic        clk,
  input  logic        en,
  input  logic [63:0] radicand,
  output logic [31:0] root
);

  logic [63:0] n_q    [SQRT_ITERS];
  logic [63:0] r_q    [SQRT_ITERS];
  logic [63:0] n_p    [SQRT_ITERS];
  logic [63:0] r_p    [SQRT_ITERS];
  logic [63:0] n_next [SQRT_ITERS];
  logic [63:0] r_next [SQRT_ITERS];
  logic [63:0] trial  [SQRT_ITERS];

  always_comb begin
    n_p[0] = radicand;
    r_p[0] = '0;
    for (int i = 1; i < SQRT_ITERS; i++) begin
      n_p[i] = n_q[i-1];
      r_p[i] = r_q[i-1];
    end
    for (int i = 0; i < SQRT_ITERS; i++) begin
      trial[i] = r_p[i] + (64'd1 << (2 * (SQRT_ITERS - 1 - i)));
      if (n_p[i] >= trial[i]) begin
        n_next[i] = n_p[i] - trial[i];
        r_next[i] = (r_p[i] >> 1) + (64'd1 << (2 * (SQRT_ITERS - 1 - i)));
      end else begin
        n_next[i] = n_p[i];
        r_next[i] = r_p[i] >> 1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < SQRT_ITERS; i++) begin
        n_q[i] <= n_next[i];
        r_q[i] <= r_next[i];
      end
    end
  end

  assign root = r_q[SQRT_ITERS-1][31:0];

endmodule

FILE: rtl/haversine_distance_unit.sv
`timescale 1ns / 1ps
// Pipeline: an accepted point transfer passes through 103 register stages
// to its distance; one point pair per cycle while no result is stalled. The
// depth is set by the two 30-stage CORDICs and the 32-stage square root.
// Reset (rst, synchronous): clears all valid bits and loads the radius
// register with 6373 km; datapath registers are not reset.
// ----------------------------------------------------------------------------
// Haversine great-circle distance unit
// Streams two latitude/longitude points in and one distance out, with the
// sphere radius set through an APB-style register port.
// ----------------------------------------------------------------------------
module haversine_distance_unit
  import hds_pkg::*;
(
  input  logic                clk,
  input  logic                rst,
  // Point channel
  input  logic                point_valid,
  output logic                point_stall,
  input  logic signed [23:0]  first_latitude,
  input  logic signed [24:0]  first_longitude,
  input  logic signed [23:0]  second_latitude,
  input  logic signed [24:0]  second_longitude,
  // Result channel
  output logic                result_valid,
  input  logic                result_stall,
  output logic [DIST_W-1:0]   distance,
  // Register port
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [ADDR_W-1:0]   paddr,
  input  logic [31:0]         pwdata,
  output logic [31:0]         prdata,
  output logic                pready
);

  // Stage count: 4 angle conversion, cosine CORDIC, 4 for the haversine
  // term, square root, arctangent CORDIC, 3 for scaling and the output.
  localparam int LAT = 4 + CORDIC_ITERS + 4 + SQRT_ITERS + CORDIC_ITERS + 3;

  // The four angles that need a cosine, one lane each.
  localparam int LANES     = 4;
  localparam int LANE_LAT1 = 0;
  localparam int LANE_LAT2 = 1;
  localparam int LANE_DLAT = 2;
  localparam int LANE_DLON = 3;

  // --------------------------------------------------------------------------
  // Flow control. The whole pipeline advances together. It holds only when
  // the output register carries a result that the far side stalls, so a
  // new point transfer can be taken on every cycle that no result is stalled,
  // even while earlier points are still in flight.
  // --------------------------------------------------------------------------
  logic           en;
  logic [LAT-1:0] vld;

  assign result_valid = vld[LAT-1];
  assign en           = !(result_valid && result_stall);
  assign point_stall  = !en;

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (en) begin
      vld <= {vld[LAT-2:0], point_valid};
    end
  end

  // --------------------------------------------------------------------------
  // Radius register. The write lands at the access phase of the transfer.
  // --------------------------------------------------------------------------
  logic [RADIUS_W-1:0] radius;
  logic                reg_write;

  assign pready    = 1'b1;
  assign reg_write = psel && penable && pwrite && pready;
  assign prdata    = (paddr == ADDR_RADIUS) ? 32'(radius) : 32'd0;

  always_ff @(posedge clk) begin
    if (rst) begin
      radius <= RADIUS_RESET;
    end else if (reg_write && paddr == ADDR_RADIUS) begin
      radius <= pwdata[RADIUS_W-1:0];
    end
  end

  // --------------------------------------------------------------------------
  // Stage 1: the two latitudes and both coordinate differences, split into
  // sign and magnitude. The differences are taken in degrees.
  // --------------------------------------------------------------------------
  logic signed [24:0] dlat;
  logic signed [25:0] dlon;
  logic signed [25:0] src      [LANES];
  logic        [24:0] mag_next [LANES];
  logic               s1_neg   [LANES];
  logic        [24:0] s1_mag   [LANES];

  assign dlat = 25'(second_latitude) - 25'(first_latitude);
  assign dlon = 26'(second_longitude) - 26'(first_longitude);

  always_comb begin
    src[LANE_LAT1] = 26'(first_latitude);
    src[LANE_LAT2] = 26'(second_latitude);
    src[LANE_DLAT] = 26'(dlat);
    src[LANE_DLON] = dlon;
    for (int k = 0; k < LANES; k++) begin
      mag_next[k] = src[k][25] ? 25'(-src[k]) : src[k][24:0];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int k = 0; k < LANES; k++) begin
        s1_neg[k] <= src[k][25];
        s1_mag[k] <= mag_next[k];
      end
    end
  end

  // --------------------------------------------------------------------------
  // Stage 2: estimate t = mag / 45 with a reciprocal multiply. The estimate
  // is low by at most one.
  // --------------------------------------------------------------------------
  logic [51:0] recip_prod [LANES];
  logic        s2_neg     [LANES];
  logic [24:0] s2_mag     [LANES];
  logic [19:0] s2_t       [LANES];

  always_comb begin
    for (int k = 0; k < LANES; k++) begin
      recip_prod[k] = 52'(s1_mag[k]) * 52'(RECIP_45);
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int k = 0; k < LANES; k++) begin
        s2_neg[k] <= s1_neg[k];
        s2_mag[k] <= s1_mag[k];
        s2_t[k]   <= recip_prod[k][51:32];
      end
    end
  end

  // --------------------------------------------------------------------------
  // Stage 3: remainder u = mag - 45 t, corrected once into [0, 45).
  // --------------------------------------------------------------------------
  logic [25:0] rem_wide [LANES];
  logic [6:0]  rem      [LANES];
  logic        s3_neg   [LANES];
  logic [19:0] s3_t     [LANES];
  logic [5:0]  s3_u     [LANES];

  always_comb begin
    for (int k = 0; k < LANES; k++) begin
      rem_wide[k] = 26'(s2_mag[k]) - 26'(s2_t[k]) * 26'(FRAC_DIV);
      rem[k]      = rem_wide[k][6:0];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int k = 0; k < LANES; k++) begin
        s3_neg[k] <= s2_neg[k];
        if (rem[k] >= FRAC_DIV) begin
          s3_t[k] <= s2_t[k] + 20'd1;
          s3_u[k] <= 6'(rem[k] - FRAC_DIV);
        end else begin
          s3_t[k] <= s2_t[k];
          s3_u[k] <= rem[k][5:0];
        end
      end
    end
  end

  // --------------------------------------------------------------------------
  // Stage 4: binary angle, 2^32 per turn, rounded on the magnitude and then
  // given its sign back. Whole turns fall off the top bits.
  // --------------------------------------------------------------------------
  logic [31:0] turn_mag [LANES];
  logic [31:0] turn     [LANES];

  always_comb begin
    for (int k = 0; k < LANES; k++) begin
      turn_mag[k] = {s3_t[k][18:0], 13'd0} + 32'(s3_u[k]) * 32'(FRAC_STEP);
      if (s3_u[k] >= FRAC_BUMP2) begin
        turn_mag[k] = turn_mag[k] + 32'd2;
      end else if (s3_u[k] >= FRAC_BUMP1) begin
        turn_mag[k] = turn_mag[k] + 32'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int k = 0; k < LANES; k++) begin
        turn[k] <= s3_neg[k] ? 32'd0 - turn_mag[k] : turn_mag[k];
      end
    end
  end

  // --------------------------------------------------------------------------
  // Cosine CORDICs. Angles beyond a quarter turn are folded by a half turn
  // with the start vector negated.
  // --------------------------------------------------------------------------
  localparam logic signed [COS_W-1:0] QUARTER = 34'sd1073741824;
  localparam logic signed [COS_W-1:0] HALF    = 34'sd2147483648;
  localparam logic signed [COS_W-1:0] GAIN    = $signed(34'(CORDIC_GAIN));

  logic signed [COS_W-1:0] ang   [LANES];
  logic signed [COS_W-1:0] x0    [LANES];
  logic signed [COS_W-1:0] z0    [LANES];
  logic signed [COS_W-1:0] cos_x [LANES];
  logic signed [31:0]      cos_c [LANES];

  always_comb begin
    for (int k = 0; k < LANES; k++) begin
      ang[k] = 34'($signed(turn[k]));
      if (ang[k] > QUARTER) begin
        z0[k] = ang[k] - HALF;
        x0[k] = -GAIN;
      end else if (ang[k] < -QUARTER) begin
        z0[k] = ang[k] + HALF;
        x0[k] = -GAIN;
      end else begin
        z0[k] = ang[k];
        x0[k] = GAIN;
      end
      if (cos_x[k] > QUARTER) begin
        cos_c[k] = 32'sd1073741824;
      end else if (cos_x[k] < -QUARTER) begin
        cos_c[k] = -32'sd1073741824;
      end else begin
        cos_c[k] = cos_x[k][31:0];
      end
    end
  end

  for (genvar k = 0; k < LANES; k++) begin : g_lane
    hds_cordic #(
      .W      (COS_W),
      .VECTOR (1'b0)
    ) u_cos (
      .clk   (clk),
      .en    (en),
      .x_in  (x0[k]),
      .y_in  ('0),
      .z_in  (z0[k]),
      .x_out (cos_x[k]),
      .y_out (),
      .z_out ()
    );
  end

  // --------------------------------------------------------------------------
  // Haversine term, four stages:
  //   P1: clamp cosines, hav = (1 - cos) / 2 (Q31)
  //   P2: cos1 * cos2 rounded to Q31
  //   P3: that product times hav(dlon), rounded to Q31
  //   P4: a = hav(dlat) + P3, clamped to [0, 1]
  // --------------------------------------------------------------------------
  logic signed [31:0] p1_cos1;
  logic signed [31:0] p1_cos2;
  logic        [31:0] p1_hlat;
  logic        [31:0] p1_hlon;

  always_ff @(posedge clk) begin
    if (en) begin
      p1_cos1 <= cos_c[LANE_LAT1];
      p1_cos2 <= cos_c[LANE_LAT2];
      p1_hlat <= 32'h4000_0000 - 32'(cos_c[LANE_DLAT]);
      p1_hlon <= 32'h4000_0000 - 32'(cos_c[LANE_DLON]);
    end
  end

  logic signed [63:0] cc_prod;
  logic signed [32:0] p2_p31;
  logic        [31:0] p2_hlat;
  logic        [31:0] p2_hlon;

  assign cc_prod = 64'(p1_cos1) * 64'(p1_cos2) + 64'sd268435456;

  always_ff @(posedge clk) begin
    if (en) begin
      p2_p31  <= cc_prod[61:29];
      p2_hlat <= p1_hlat;
      p2_hlon <= p1_hlon;
    end
  end

  logic signed [65:0] ph_prod;
  logic signed [32:0] p3_term;
  logic        [31:0] p3_hlat;

  assign ph_prod = 66'(p2_p31) * 66'($signed({1'b0, p2_hlon})) + 66'sd1073741824;

  always_ff @(posedge clk) begin
    if (en) begin
      p3_term <= ph_prod[63:31];
      p3_hlat <= p2_hlat;
    end
  end

  logic signed [33:0] a_sum;
  logic        [31:0] a_q;

  assign a_sum = $signed({2'b00, p3_hlat}) + 34'(p3_term);

  always_ff @(posedge clk) begin
    if (en) begin
      if (a_sum < 0) begin
        a_q <= '0;
      end else if (a_sum > 34'sd2147483648) begin
        a_q <= 32'h8000_0000;
      end else begin
        a_q <= a_sum[31:0];
      end
    end
  end

  // --------------------------------------------------------------------------
  // sqrt(a) and sqrt(1 - a) in Q31, then c / 2 = atan2 by a vectoring CORDIC.
  // --------------------------------------------------------------------------
  logic [31:0] a_comp;
  logic [31:0] root_a;
  logic [31:0] root_b;

  assign a_comp = 32'h8000_0000 - a_q;

  hds_isqrt u_sqrt_a (
    .clk      (clk),
    .en       (en),
    .radicand ({1'b0, a_q, 31'd0}),
    .root     (root_a)
  );

  hds_isqrt u_sqrt_b (
    .clk      (clk),
    .en       (en),
    .radicand ({1'b0, a_comp, 31'd0}),
    .root     (root_b)
  );

  logic signed [ATAN_W-1:0] atan_z;

  hds_cordic #(
    .W      (ATAN_W),
    .VECTOR (1'b1)
  ) u_atan (
    .clk   (clk),
    .en    (en),
    .x_in  ($signed({3'b000, root_b})),
    .y_in  ($signed({3'b000, root_a})),
    .z_in  ('0),
    .x_out (),
    .y_out (),
    .z_out (atan_z)
  );

  // --------------------------------------------------------------------------
  // Scaling: theta * pi, then times the radius in a 30-bit upper and a 32-bit
  // lower half, then rounding to the output grid with saturation.
  // --------------------------------------------------------------------------
  logic [30:0] theta;
  logic [61:0] k_q;

  always_comb begin
    if (atan_z < 0) begin
      theta = '0;
    end else if (atan_z > 35'sd1073741824) begin
      theta = 31'h4000_0000;
    end else begin
      theta = atan_z[30:0];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      k_q <= 62'(theta) * 62'(PI_Q29);
    end
  end

  logic [42:0] m_hi;
  logic [44:0] m_lo;

  always_ff @(posedge clk) begin
    if (en) begin
      m_hi <= 43'(radius) * 43'(k_q[61:32]);
      m_lo <= 45'(radius) * 45'(k_q[31:0]);
    end
  end

  logic [45:0] m_sum;
  logic [45:0] m_round;

  assign m_sum   = 46'(m_hi) + 46'(m_lo[44:32]);
  assign m_round = m_sum + (46'd1 << (DIST_SHIFT - 1));

  always_ff @(posedge clk) begin
    if (en) begin
      if ((m_round >> DIST_SHIFT) > 46'((1 << DIST_W) - 1)) begin
        distance <= '1;
      end else begin
        distance <= m_round[DIST_SHIFT +: DIST_W];
      end
    end
  end

  // --------------------------------------------------------------------------
  // Assertions
  // --------------------------------------------------------------------------
  // The point side is only held back by a stalled, pending result.
  a_stall_cause : assert property (@(posedge clk) disable iff (rst)
    point_stall |-> result_valid)
    else $error("point side stalled without a pending result");

  // A held pipeline neither drops nor creates items.
  a_hold_valid : assert property (@(posedge clk) disable iff (rst)
    !en |=> $stable(vld))
    else $error("valid bits moved while the pipeline was held");

  // Reset empties the pipeline.
  a_reset_empty : assert property (@(posedge clk)
    rst |=> !result_valid)
    else $error("result offered right after reset");

endmodule
